[hdl/slug_pkg.sv]
`default_nettype none
package slug_pkg;

    localparam int CapWidth = 16;
    localparam logic [CapWidth-1:0] CapReset = 16'd128;
    localparam int QueueDepth = 4;

    localparam logic [6:0] CharDash = 7'h2D;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } slug_in_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       char_valid;
        logic       slug_end;
    } slug_out_t;

    // Up to three results per byte, packed in order
    typedef struct packed {
        logic [1:0]      count;
        slug_out_t [2:0] items;
    } slug_group_t;

    // First letter of each mapping for U+00C0..U+017F; dash means none
    localparam string FirstLetters =
        {"aaaaaaaceeeeiiii", "dnooooo-ouuuuyts", "aaaaaaaceeeeiiii", "dnooooo-ouuuuyty",
         "aaaaaaccccccccdd", "ddeeeeeeeeeegggg", "gggghhhhiiiiiiii", "iiiijjkkklllllll",
         "lllnnnnnnnnnoooo", "oooorrrrrrssssss", "ssttttttuuuuuuuu", "uuuuwwyyyzzzzzzs"};

    function automatic logic [6:0] first_letter(input logic [8:0] idx);
        logic [7:0] c;
        c = 8'(FirstLetters[idx]);
        return c[6:0];
    endfunction

    function automatic logic [6:0] second_letter(input logic [20:0] cp);
        logic [6:0] s;
        unique case (cp)
            21'hC6, 21'hE6, 21'h152, 21'h153: s = 7'h65;
            21'hDE, 21'hFE:                   s = 7'h68;
            21'hDF:                           s = 7'h73;
            21'h132, 21'h133:                 s = 7'h6A;
            default:                          s = 7'h00;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

[hdl/utf8_transliterating_slug_maker_core.sv]
// Channel  | Handshake         | Payload
// in       | push / full       | in_data  (slug_in_t)
// out      | pop / empty       | out_data (slug_out_t)
// cfg      | cfg_valid / ready | cfg_data (capacity)
// One byte is decoded per cycle while full is low; the front decode path sets that rate.
// Each byte gives zero to three results, drained one per cycle while pop is held, from a
// four-group queue; full rises when the queue holds four groups.
// Reset clears the decoder, queue and sets capacity to 128.
`default_nettype none
module utf8_transliterating_slug_maker_core
    import slug_pkg::*;
#(
    parameter int DEPTH = QueueDepth
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire slug_in_t            in_data,
    output logic                     empty,
    input  wire logic                pop,
    output slug_out_t                out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CapWidth-1:0] cfg_data
);

    logic [CapWidth-1:0] cap_reg;
    slug_group_t         grp;
    logic                take;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CapReset;
        else if (cfg_valid)
            cap_reg <= cfg_data;
    end

    assign take = push && !full;

    slug_front #(.CAP_WIDTH(CapWidth)) u_front (
        .clk(clk), .rst_n(rst_n), .capacity(cap_reg),
        .take(take), .in_item(in_data), .group(grp)
    );

    slug_back #(.DEPTH(DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .wr_en(take && grp.count != 2'd0),
        .wr_group(grp), .q_full(full), .head(out_data),
        .empty(empty), .pop(pop)
    );

endmodule
`default_nettype wire

[hdl/slug_front.sv]
`default_nettype none
module slug_front
    import slug_pkg::*;
#(
    parameter int CAP_WIDTH = CapWidth
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [CAP_WIDTH-1:0] capacity,
    input  wire logic                 take,
    input  wire slug_in_t             in_item,
    output slug_group_t               group
);

    logic [20:0]          partial_reg, partial_next;
    logic [1:0]           cont_reg, cont_next;
    logic [2:0]           seqlen_reg, seqlen_next;
    logic                 dash_reg, dash_next;
    logic [CAP_WIDTH-1:0] written_reg, written_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            cont_reg    <= '0;
            seqlen_reg  <= '0;
            dash_reg    <= 1'b0;
            written_reg <= '0;
        end
        else if (take)
        begin
            partial_reg <= partial_next;
            cont_reg    <= cont_next;
            seqlen_reg  <= seqlen_next;
            dash_reg    <= dash_next;
            written_reg <= written_next;
        end
    end

    // Decode one byte into up to three characters
    always_comb
    begin
        logic [7:0]           b;
        logic [20:0]          cp;
        logic                 bad, fresh, sep, done;
        logic [6:0]           l1, l2;
        logic [1:0]           nl;
        logic [CAP_WIDTH:0]   limit, w;
        logic [1:0]           n;
        logic [6:0]           ch [3];
        b            = in_item.in_byte;
        partial_next = partial_reg;
        cont_next    = cont_reg;
        seqlen_next  = seqlen_reg;
        dash_next    = dash_reg;
        sep          = 1'b0;
        fresh        = 1'b0;
        done         = 1'b0;
        nl           = 2'd0;
        l1           = '0;
        l2           = '0;
        cp           = '0;
        bad          = 1'b0;
        n            = 2'd0;
        ch[0] = '0; ch[1] = '0; ch[2] = '0;
        limit = (capacity == '0) ? '0 : {1'b0, capacity} - 1'b1;
        w     = {1'b0, written_reg};

        if (cont_reg != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                cp = ((partial_reg << 6) | {15'd0, b[5:0]});
                partial_next = cp;
                cont_next = cont_reg - 2'd1;
                done = (cont_reg == 2'd1);
            end
            else
            begin
                cont_next = 2'd0;
                sep   = 1'b1;
                fresh = 1'b1;
            end
        end
        else
            fresh = 1'b1;

        // A broken sequence counts as a separator before the new byte
        if (sep && written_reg != '0)
            dash_next = 1'b1;

        if (done)
        begin
            bad = (seqlen_reg == 3'd2 && cp < 21'h80) ||
                  (seqlen_reg == 3'd3 && cp < 21'h800) ||
                  (seqlen_reg == 3'd4 && cp < 21'h10000) ||
                  (cp >= 21'hD800 && cp <= 21'hDFFF) || (cp > 21'h10FFFF);
            if (!bad && cp >= 21'hC0 && cp <= 21'h17F)
                l1 = first_letter(9'(cp - 21'hC0));
            if (!bad && cp >= 21'hC0 && cp <= 21'h17F && l1 != CharDash)
            begin
                l2 = second_letter(cp);
                nl = (l2 != '0) ? 2'd2 : 2'd1;
            end
            else if (written_reg != '0)
                dash_next = 1'b1;
        end
        else if (fresh)
        begin
            if (!b[7])
            begin
                if (b >= 8'h41 && b <= 8'h5A)
                begin
                    l1 = b[6:0] + 7'h20;
                    nl = 2'd1;
                end
                else if ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'h30 && b <= 8'h39))
                begin
                    l1 = b[6:0];
                    nl = 2'd1;
                end
                else if (w != '0 || dash_next)
                    dash_next = (written_reg != '0) | dash_next;
            end
            else if (b[7:5] == 3'b110)
            begin
                partial_next = {16'd0, b[4:0]}; seqlen_next = 3'd2; cont_next = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                partial_next = {17'd0, b[3:0]}; seqlen_next = 3'd3; cont_next = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                partial_next = {18'd0, b[2:0]}; seqlen_next = 3'd4; cont_next = 2'd3;
            end
            else if (written_reg != '0)
                dash_next = 1'b1;
        end

        // Emit letters with the pending dash rule and capacity limit
        if (nl != 2'd0)
        begin
            if (dash_next)
            begin
                if (w + 2 <= limit)
                begin
                    ch[0] = CharDash; ch[1] = l1; n = 2'd2;
                    w = w + (CAP_WIDTH+1)'(2); dash_next = 1'b0;
                end
            end
            else if (w + 1 <= limit)
            begin
                ch[0] = l1; n = 2'd1; w = w + (CAP_WIDTH+1)'(1);
            end
        end
        if (nl == 2'd2)
        begin
            if (dash_next)
            begin
                if (w + 2 <= limit)
                begin
                    ch[n] = CharDash; ch[n+2'd1] = l2; n = n + 2'd2;
                    w = w + (CAP_WIDTH+1)'(2); dash_next = 1'b0;
                end
            end
            else if (w + 1 <= limit)
            begin
                ch[n] = l2; n = n + 2'd1; w = w + (CAP_WIDTH+1)'(1);
            end
        end
        written_next = w[CAP_WIDTH-1:0];

        group.count = n;
        for (int i = 0; i < 3; i++)
        begin
            group.items[i].out_char   = ch[i];
            group.items[i].char_valid = 1'b1;
            group.items[i].slug_end   = in_item.in_last && (32'(i) == 32'(n) - 1);
        end
        if (in_item.in_last)
        begin
            if (n == 2'd0)
            begin
                group.count = 2'd1;
                group.items[0].out_char   = '0;
                group.items[0].char_valid = 1'b0;
                group.items[0].slug_end   = 1'b1;
            end
            partial_next = '0;
            cont_next    = '0;
            seqlen_next  = '0;
            dash_next    = 1'b0;
            written_next = '0;
        end
    end

endmodule
`default_nettype wire

[hdl/slug_back.sv]
`default_nettype none
module slug_back
    import slug_pkg::*;
#(
    parameter int DEPTH = QueueDepth
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire slug_group_t wr_group,
    output logic             q_full,
    output slug_out_t        head,
    output logic             empty,
    input  wire logic        pop
);

    localparam int AW = $clog2(DEPTH);

    slug_group_t     q_mem [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;
    logic [1:0]      sub_reg;
    logic            rd_done;

    // Queue of byte groups between decode and output
    always_ff @(posedge clk)
    begin
        if (wr_en)
            q_mem[wp_reg] <= wr_group;
    end

    assign empty   = (cnt_reg == '0);
    assign q_full  = (cnt_reg == (AW+1)'(DEPTH));
    assign head    = q_mem[rp_reg].items[sub_reg];
    assign rd_done = pop && !empty && (sub_reg + 2'd1 == q_mem[rp_reg].count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
            sub_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (rd_done)
            begin
                rp_reg  <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
                sub_reg <= '0;
            end
            else if (pop && !empty)
                sub_reg <= sub_reg + 2'd1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_done);
        end
    end

endmodule
`default_nettype wire
